### design/ihc_pkg.sv
package ihc_pkg;

    // Longest frame that is counted; the byte counter stops here.
    localparam int FRAME_MAX = 65536;
    localparam int POS_W     = $clog2(FRAME_MAX + 1);

    // Frame layout
    localparam int ETH_HDR_LEN  = 14;
    localparam int OFF_PROTO    = 23;
    localparam int OFF_SRC_ADDR = 26;
    localparam int OFF_DST_ADDR = 30;
    localparam int MIN_KEEP_LEN = 34;
    localparam int TCP_HDR_LEN  = 20;
    localparam int UDP_HDR_LEN  = 8;

    localparam logic [3:0] VERSION_IPV4 = 4'd4;

    // IPv4 protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_IGMP = 8'd2;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_IPV6 = 8'd41;
    localparam logic [7:0] PROTO_OSPF = 8'd89;

    // Protocol class codes
    localparam logic [2:0] CLASS_TCP   = 3'd0;
    localparam logic [2:0] CLASS_UDP   = 3'd1;
    localparam logic [2:0] CLASS_ICMP  = 3'd2;
    localparam logic [2:0] CLASS_IGMP  = 3'd3;
    localparam logic [2:0] CLASS_IPV6  = 3'd4;
    localparam logic [2:0] CLASS_OSPF  = 3'd5;
    localparam logic [2:0] CLASS_OTHER = 3'd6;

    localparam logic [4:0] SVC_UNKNOWN = 5'd0;
    localparam int         SVC_COUNT   = 19;
    localparam logic [4:0] SVC_MAX     = 5'(SVC_COUNT);

    localparam logic [15:0] SVC_PORTS [SVC_COUNT] = '{
        16'd20, 16'd21, 16'd22, 16'd23, 16'd25, 16'd53, 16'd67, 16'd68, 16'd80,
        16'd110, 16'd123, 16'd143, 16'd443, 16'd445, 16'd587, 16'd993,
        16'd3306, 16'd3389, 16'd5432
    };

    typedef logic [POS_W-1:0] t_pos;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        recorded;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [2:0]  proto_class;
        logic [7:0]  proto_number;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [4:0]  service_code;
        logic [16:0] frame_length;
    } t_out_item;

    // Everything captured from one frame, taken on its last byte
    typedef struct packed {
        t_pos        len;
        logic [7:0]  vbyte;
        logic [7:0]  proto;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } t_summary;

    // Table index (1-based) of a well-known port, zero when not listed
    function automatic logic [4:0] svc_lookup(input logic [15:0] port);
        logic [4:0] code;
        code = SVC_UNKNOWN;
        for (int k = SVC_COUNT - 1; k >= 0; k--) begin
            if (SVC_PORTS[k] == port) begin
                code = 5'(k + 1);
            end
        end
        return code;
    endfunction

endpackage

### design/ihc_capture.sv
module ihc_capture
    import ihc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output t_summary o_summary
);

    t_pos        r_pos,      n_pos;
    logic [7:0]  r_vbyte,    n_vbyte;
    logic [7:0]  r_proto,    n_proto;
    logic [31:0] r_src_addr, n_src_addr;
    logic [31:0] r_dst_addr, n_dst_addr;
    logic [15:0] r_src_port, n_src_port;
    logic [15:0] r_dst_port, n_dst_port;
    logic [6:0]  port_off;
    logic [7:0]  b;

    assign b = i_item.data_byte;

    always_comb begin
        n_pos      = r_pos;
        n_vbyte    = r_vbyte;
        n_proto    = r_proto;
        n_src_addr = r_src_addr;
        n_dst_addr = r_dst_addr;
        n_src_port = r_src_port;
        n_dst_port = r_dst_port;
        port_off   = 7'(ETH_HDR_LEN) + {1'b0, r_vbyte[3:0], 2'b00};
        if (r_pos < t_pos'(FRAME_MAX)) begin
            if (r_pos == t_pos'(ETH_HDR_LEN)) begin
                n_vbyte = b;
            end
            // port offset follows the header length just taken
            port_off = 7'(ETH_HDR_LEN) + {1'b0, n_vbyte[3:0], 2'b00};
            if (r_pos == t_pos'(OFF_PROTO)) begin
                n_proto = b;
            end
            for (int k = 0; k < 4; k++) begin
                if (r_pos == t_pos'(OFF_SRC_ADDR + k)) begin
                    n_src_addr[8*(3-k) +: 8] = b;
                end
                if (r_pos == t_pos'(OFF_DST_ADDR + k)) begin
                    n_dst_addr[8*(3-k) +: 8] = b;
                end
            end
            if (r_pos == t_pos'(port_off)) begin
                n_src_port[15:8] = b;
            end
            if (r_pos == t_pos'(port_off + 7'd1)) begin
                n_src_port[7:0] = b;
            end
            if (r_pos == t_pos'(port_off + 7'd2)) begin
                n_dst_port[15:8] = b;
            end
            if (r_pos == t_pos'(port_off + 7'd3)) begin
                n_dst_port[7:0] = b;
            end
            n_pos = r_pos + t_pos'(1);
        end
    end

    assign o_summary = '{
        len:      n_pos,
        vbyte:    n_vbyte,
        proto:    n_proto,
        src_addr: n_src_addr,
        dst_addr: n_dst_addr,
        src_port: n_src_port,
        dst_port: n_dst_port
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_item.last_byte)) begin
            r_pos      <= '0;
            r_vbyte    <= '0;
            r_proto    <= '0;
            r_src_addr <= '0;
            r_dst_addr <= '0;
            r_src_port <= '0;
            r_dst_port <= '0;
        end else if (i_accept) begin
            r_pos      <= n_pos;
            r_vbyte    <= n_vbyte;
            r_proto    <= n_proto;
            r_src_addr <= n_src_addr;
            r_dst_addr <= n_dst_addr;
            r_src_port <= n_src_port;
            r_dst_port <= n_dst_port;
        end
    end

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= t_pos'(FRAME_MAX))
        else $error("byte counter ran past the frame limit");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.last_byte |=> r_pos == '0 && r_vbyte == '0)
        else $error("capture state not cleared after last byte");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_item.last_byte && r_pos < t_pos'(FRAME_MAX)
        |=> r_pos == $past(r_pos) + t_pos'(1))
        else $error("byte counter did not advance");

endmodule

### design/ihc_classify.sv
module ihc_classify
    import ihc_pkg::*;
(
    input  t_summary  i_summary,
    output t_out_item o_record
);

    logic [6:0]  port_off;
    logic        keep;
    logic        tcp_ok;
    logic        udp_ok;
    logic [2:0]  cls;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [4:0]  svc_dst;
    logic [4:0]  svc;

    assign port_off = 7'(ETH_HDR_LEN) + {1'b0, i_summary.vbyte[3:0], 2'b00};
    assign keep     = (i_summary.vbyte[7:4] == VERSION_IPV4)
                   && (i_summary.len >= t_pos'(MIN_KEEP_LEN));
    assign tcp_ok   = (i_summary.proto == PROTO_TCP)
                   && (i_summary.len >= t_pos'(port_off + 7'(TCP_HDR_LEN)));
    assign udp_ok   = (i_summary.proto == PROTO_UDP)
                   && (i_summary.len >= t_pos'(port_off + 7'(UDP_HDR_LEN)));

    always_comb begin
        sp = '0;
        dp = '0;
        if (tcp_ok) begin
            cls = CLASS_TCP;
            sp  = i_summary.src_port;
            dp  = i_summary.dst_port;
        end else if (udp_ok) begin
            cls = CLASS_UDP;
            sp  = i_summary.src_port;
            dp  = i_summary.dst_port;
        end else begin
            case (i_summary.proto)
                PROTO_ICMP: cls = CLASS_ICMP;
                PROTO_IGMP: cls = CLASS_IGMP;
                PROTO_IPV6: cls = CLASS_IPV6;
                PROTO_OSPF: cls = CLASS_OSPF;
                default:    cls = CLASS_OTHER;
            endcase
        end
    end

    // Destination port wins; fall back to the source port
    assign svc_dst = svc_lookup(dp);
    assign svc     = (svc_dst != SVC_UNKNOWN) ? svc_dst : svc_lookup(sp);

    always_comb begin
        o_record              = '0;
        o_record.frame_length = 17'(i_summary.len);
        if (keep) begin
            o_record.recorded       = 1'b1;
            o_record.source_address = i_summary.src_addr;
            o_record.dest_address   = i_summary.dst_addr;
            o_record.proto_class    = cls;
            o_record.proto_number   = i_summary.proto;
            o_record.source_port    = sp;
            o_record.dest_port      = dp;
            o_record.service_code   = svc;
        end
    end

endmodule

### design/ipv4_header_classifier_top.sv
// IPv4 header classifier. Feed an Ethernet frame one byte per item, in wire
// order, with last_byte set on its final byte; a new byte may be accepted in
// every cycle while input ready is high. The block picks out the IPv4
// version/IHL byte (offset 14), the protocol byte (offset 23), source and
// destination addresses (offsets 26-33) and the TCP/UDP ports just after the
// IPv4 header. For each frame it returns exactly one record, which passes
// through the summary register and then the result register before it is
// presented on the output; output stalls push it back. The record carries a
// recorded flag (IPv4 and at least 34 bytes; all fields but frame_length are
// zero otherwise), a protocol class, the ports (zero unless the frame is long
// enough to hold the TCP or UDP header), a well-known service code and the
// byte count, which saturates at FRAME_MAX. Throughput is one byte per cycle
// while input ready is high. Input ready drops only when the summary and
// result registers both hold records that the output side has not taken.
module ipv4_header_classifier_top
    import ihc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      in_accept;
    logic      out_advance;
    t_summary  cap_summary;
    t_out_item cls_record;

    // Summary stage: the frame's capture, frozen on its last byte
    logic      r_sum_valid;
    t_summary  r_sum;

    // Result stage: the finished record waiting for the consumer
    logic      r_out_valid;
    t_out_item r_out;

    // The result register frees up when empty or being taken this cycle;
    // the summary register then frees up behind it.
    assign out_advance = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_sum_valid || out_advance;
    assign in_accept   = i_in_valid && o_in_ready;

    ihc_capture u_capture (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_item    (i_in_item),
        .o_summary (cap_summary)
    );

    ihc_classify u_classify (
        .i_summary (r_sum),
        .o_record  (cls_record)
    );

    // Control: summary moves on input ready, result on a free result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_sum_valid <= in_accept && i_in_item.last_byte;
            end
            if (out_advance) begin
                r_out_valid <= r_sum_valid;
            end
        end
    end

    // Payload: load on the last byte and on a stage move, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_accept && i_in_item.last_byte) begin
            r_sum <= cap_summary;
        end
        if (out_advance && r_sum_valid) begin
            r_out <= cls_record;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_sum_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sum_valid) |-> $past(in_accept && i_in_item.last_byte))
        else $error("summary appeared without a last byte");

    a_dropped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.recorded |->
            o_out_item.source_address == '0 && o_out_item.dest_address == '0 &&
            o_out_item.proto_number == '0 && o_out_item.service_code == '0)
        else $error("discarded record carries nonzero fields");

    a_ports_only_tcp_udp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.proto_class != CLASS_TCP &&
        o_out_item.proto_class != CLASS_UDP |->
            o_out_item.source_port == '0 && o_out_item.dest_port == '0)
        else $error("ports reported for a non TCP/UDP record");

    a_svc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.service_code <= SVC_MAX &&
            o_out_item.proto_class <= CLASS_OTHER)
        else $error("service code or class out of range");

endmodule
